FILE: hw/rtl/tgbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbe_pkg
// Shared types and constants of the tile grid boundary edge extractor.
// ----------------------------------------------------------------------------
package tgbe_pkg;

  localparam int DIM_W     = 11;
  localparam int GRID_W    = 7;
  localparam int TILE_W    = 8;
  localparam int POS_W     = 6;
  localparam int PIX_W     = POS_W + TILE_W;
  localparam int COORD_W   = 15;
  localparam int CFG_IDX_W = 8;
  localparam int HALF_LEN  = 16;
  localparam int FULL_LEN  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 8'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    SIDE_TOP,
    SIDE_BOTTOM,
    SIDE_LEFT,
    SIDE_RIGHT
  } side_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_C,
    ST_RD_U,
    ST_RD_D,
    ST_MASK,
    ST_EMIT,
    ST_WR
  } state_e;

  typedef struct packed {
    logic [DIM_W-1:0]  cols;
    logic [DIM_W-1:0]  rows;
    logic [TILE_W-1:0] tile_w;
    logic [TILE_W-1:0] tile_h;
  } cfg_t;

endpackage

FILE: hw/rtl/tile_grid_boundary_edges.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_grid_boundary_edges
// Occupancy grid of wall tiles that emits the exposed edge segments of a cell.
// ----------------------------------------------------------------------------
// A write beat is accepted, then its row is read and written back.
// A query reads three grid rows (centre, above, below) and builds a side mask;
// its segments then follow one per cycle while m_axis_tready is high. An
// enclosed cell yields no segments; an empty cell ends after the centre read.
// Out-of-grid beats are accepted and dropped.
// After reset the grid is cleared one row per cycle, all MAX_ROWS rows, while
// s_axis_tready stays low; configuration writes are taken throughout.
module tile_grid_boundary_edges #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // row[5:0], col[11:6], occupied[12]
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // x_start, y_start, x_end, y_end
  output logic [1:0]  m_axis_tuser,  // side
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  import tgbe_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);

  cfg_t                cfg;
  logic                mem_we;
  logic [RW-1:0]       mem_waddr, mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata, mem_rdata;
  logic signed [COORD_W-1:0] xs, ys, xe, ye;
  side_e               side;

  tgbe_cfg #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tgbe_grid_mem #(
    .ROWS(MAX_ROWS),
    .COLS(MAX_COLS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tgbe_ctrl #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_mode_i     (s_axis_tuser),
    .in_row_i      (s_axis_tdata[5:0]),
    .in_col_i      (s_axis_tdata[11:6]),
    .in_occ_i      (s_axis_tdata[12]),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_x_start_o (xs),
    .out_y_start_o (ys),
    .out_x_end_o   (xe),
    .out_y_end_o   (ye),
    .out_side_o    (side),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, ye, xe, ys, xs};
  assign m_axis_tuser = side;

endmodule

FILE: hw/rtl/tgbe_grid_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbe_grid_mem
// Row-wide occupancy memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tgbe_grid_mem #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [$clog2(ROWS)-1:0] waddr_i,
  input  logic [COLS-1:0]         wdata_i,
  input  logic [$clog2(ROWS)-1:0] raddr_i,
  output logic [COLS-1:0]         rdata_o
);

  logic [COLS-1:0] mem [ROWS];
  logic [COLS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tgbe_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbe_cfg
// Configuration registers and the clamped active grid size.
// ----------------------------------------------------------------------------
module tgbe_cfg #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [tgbe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]               cfg_data_i,
  output tgbe_pkg::cfg_t           cfg_o
);

  import tgbe_pkg::*;

  logic [GRID_W-1:0] grid_w_q, grid_h_q;
  logic [TILE_W-1:0] tile_w_q, tile_h_q;
  logic [DIM_W-1:0]  gw_ext, gh_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= 7'd64;
      grid_h_q <= 7'd64;
      tile_w_q <= 8'd32;
      tile_h_q <= 8'd32;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GRID_WIDTH:  grid_w_q <= cfg_data_i[GRID_W-1:0];
        REG_GRID_HEIGHT: grid_h_q <= cfg_data_i[GRID_W-1:0];
        REG_TILE_WIDTH:  tile_w_q <= cfg_data_i;
        REG_TILE_HEIGHT: tile_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign gw_ext = DIM_W'(grid_w_q);
  assign gh_ext = DIM_W'(grid_h_q);

  always_comb begin
    cfg_o.tile_w = tile_w_q;
    cfg_o.tile_h = tile_h_q;
    priority if (gw_ext == '0) begin
      cfg_o.cols = DIM_W'(1);
    end else if (gw_ext > DIM_W'(MAX_COLS)) begin
      cfg_o.cols = DIM_W'(MAX_COLS);
    end else begin
      cfg_o.cols = gw_ext;
    end
    priority if (gh_ext == '0) begin
      cfg_o.rows = DIM_W'(1);
    end else if (gh_ext > DIM_W'(MAX_ROWS)) begin
      cfg_o.rows = DIM_W'(MAX_ROWS);
    end else begin
      cfg_o.rows = gh_ext;
    end
  end

endmodule

FILE: hw/rtl/tgbe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbe_ctrl
// Sequencer: grid clear, row reads and write-back, side mask and segment output register.
// ----------------------------------------------------------------------------
module tgbe_ctrl #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tgbe_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_mode_i,
  input  logic [tgbe_pkg::POS_W-1:0]  in_row_i,
  input  logic [tgbe_pkg::POS_W-1:0]  in_col_i,
  input  logic                        in_occ_i,
  output logic                        mem_we_o,
  output logic [$clog2(MAX_ROWS)-1:0] mem_waddr_o,
  output logic [MAX_COLS-1:0]         mem_wdata_o,
  output logic [$clog2(MAX_ROWS)-1:0] mem_raddr_o,
  input  logic [MAX_COLS-1:0]         mem_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [tgbe_pkg::COORD_W-1:0] out_x_start_o,
  output logic signed [tgbe_pkg::COORD_W-1:0] out_y_start_o,
  output logic signed [tgbe_pkg::COORD_W-1:0] out_x_end_o,
  output logic signed [tgbe_pkg::COORD_W-1:0] out_y_end_o,
  output tgbe_pkg::side_e             out_side_o,
  output logic                        out_last_o
);

  import tgbe_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  state_e state_q, state_d;
  logic [RW-1:0] clr_q;
  logic          out_valid_q;

  logic             mode_q, occ_q;
  logic [POS_W-1:0] row_q, col_q;
  logic [PIX_W-1:0] x_q, y_q;
  logic             left_q, right_q, up_q;
  logic [3:0]       mask_q;

  logic signed [COORD_W-1:0] xs_q, ys_q, xe_q, ye_q;
  side_e                     side_q;
  logic                      last_q;

  logic [DIM_W-1:0] row_ext, col_ext;
  logic [RW-1:0]    row_idx;
  logic [CW-1:0]    col_idx, col_lo, col_hi;
  logic             in_range, accept, cell_bit, load;
  logic [3:0]       pick, rest;
  side_e            pick_side;
  logic [COORD_W-1:0] lx, rx, ty, by;

  assign row_ext = DIM_W'(row_q);
  assign col_ext = DIM_W'(col_q);
  assign row_idx = RW'(row_ext);
  assign col_idx = CW'(col_ext);
  assign col_lo  = CW'(col_ext - DIM_W'(1));
  assign col_hi  = CW'(col_ext + DIM_W'(1));
  assign cell_bit = mem_rdata_i[col_idx];

  assign in_range = (DIM_W'(in_row_i) < cfg_i.rows) && (DIM_W'(in_col_i) < cfg_i.cols);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    pick      = 4'b0000;
    pick_side = SIDE_TOP;
    priority if (mask_q[0]) begin
      pick = 4'b0001;
      pick_side = SIDE_TOP;
    end else if (mask_q[1]) begin
      pick = 4'b0010;
      pick_side = SIDE_BOTTOM;
    end else if (mask_q[2]) begin
      pick = 4'b0100;
      pick_side = SIDE_LEFT;
    end else if (mask_q[3]) begin
      pick = 4'b1000;
      pick_side = SIDE_RIGHT;
    end else begin
      pick = 4'b0000;
    end
  end

  assign rest = mask_q & ~pick;
  assign load = (state_q == ST_EMIT) && (mask_q != 4'b0000) && (!out_valid_q || out_ready_i);

  assign lx = COORD_W'(x_q) - COORD_W'(HALF_LEN);
  assign rx = lx + COORD_W'(FULL_LEN);
  assign ty = COORD_W'(y_q) - COORD_W'(HALF_LEN);
  assign by = COORD_W'(y_q) + COORD_W'(HALF_LEN);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == RW'(MAX_ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_range) begin
          state_d = ST_RD_C;
        end
      end
      ST_RD_C: state_d = (mode_q == MODE_WRITE) ? ST_WR : ST_RD_U;
      ST_WR:   state_d = ST_IDLE;
      ST_RD_U: state_d = cell_bit ? ST_RD_D : ST_IDLE;
      ST_RD_D: state_d = ST_MASK;
      ST_MASK: state_d = ST_EMIT;
      ST_EMIT: begin
        if (mask_q == 4'b0000 || (load && rest == 4'b0000)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = row_idx;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = row_idx;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
      end
      ST_WR: begin
        mem_we_o             = 1'b1;
        mem_wdata_o[col_idx] = occ_q;
      end
      ST_RD_U: mem_raddr_o = RW'(row_ext - DIM_W'(1));
      ST_RD_D: mem_raddr_o = RW'(row_ext + DIM_W'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      mask_q      <= 4'b0000;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + RW'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_MASK) begin
        mask_q <= {right_q, left_q,
                   ((row_ext + DIM_W'(1)) >= cfg_i.rows) || !cell_bit, up_q};
      end else if (load) begin
        mask_q <= rest;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_mode_i;
      row_q  <= in_row_i;
      col_q  <= in_col_i;
      occ_q  <= in_occ_i;
    end
    if (state_q == ST_RD_C) begin
      x_q <= PIX_W'(PIX_W'(col_q) * PIX_W'(cfg_i.tile_w));
      y_q <= PIX_W'(PIX_W'(row_q) * PIX_W'(cfg_i.tile_h));
    end
    if (state_q == ST_RD_U) begin
      left_q  <= (col_q == '0) || !mem_rdata_i[col_lo];
      right_q <= ((col_ext + DIM_W'(1)) >= cfg_i.cols) || !mem_rdata_i[col_hi];
    end
    if (state_q == ST_RD_D) begin
      up_q <= (row_q == '0) || !cell_bit;
    end
    if (load) begin
      side_q <= pick_side;
      last_q <= (rest == 4'b0000);
      unique case (pick_side)
        SIDE_TOP: begin
          xs_q <= lx; ys_q <= ty; xe_q <= rx; ye_q <= ty;
        end
        SIDE_BOTTOM: begin
          xs_q <= lx; ys_q <= by; xe_q <= rx; ye_q <= by;
        end
        SIDE_LEFT: begin
          xs_q <= lx; ys_q <= ty; xe_q <= lx; ye_q <= by;
        end
        SIDE_RIGHT: begin
          xs_q <= rx; ys_q <= ty; xe_q <= rx; ye_q <= by;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_start_o = xs_q;
  assign out_y_start_o = ys_q;
  assign out_x_end_o   = xe_q;
  assign out_y_end_o   = ye_q;
  assign out_side_o    = side_q;
  assign out_last_o    = last_q;

endmodule

FILE: hw/rtl/tgbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbe_checker
// Port-level checks of the segment stream, bound to the top level.
// ----------------------------------------------------------------------------
module tgbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  import tgbe_pkg::*;

  logic m_beat, s_beat;

  assign m_beat = m_axis_tvalid && m_axis_tready;
  assign s_beat = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_beat && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a segment burst");

  a_side_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_beat && !m_axis_tlast |=> m_axis_tuser > $past(m_axis_tuser))
    else $error("segment sides out of order");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && (s_axis_tuser == MODE_WRITE) |=> !$rose(m_axis_tvalid))
    else $error("write beat produced a segment");

endmodule

bind tile_grid_boundary_edges tgbe_checker u_tgbe_checker (.*);
